[rtl/core/efd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// efd_pkg: shared types and constants for the earliest-finish dispatcher
// Field widths, register map, speed slot lookup and divider handshake types.
// ----------------------------------------------------------------------------
package efd_pkg;

   // machine and type counts
   localparam int MACHINES = 4;
   localparam int TYPES    = 4;
   localparam int MACH_W   = (MACHINES > 1) ? $clog2(MACHINES) : 1;

   // payload widths
   localparam int TIME_W  = 32;
   localparam int WORK_W  = 24;
   localparam int TYPE_W  = 3;
   localparam int SPEED_W = 16;
   localparam int CHOSEN_W = 2;
   localparam int ROW_W   = SPEED_W * 4;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_BASE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_AVAIL_BASE = CSR_IDX_W'(4);

   // dispatch functions
   localparam logic FUNC_DISPATCH = 1'b0;
   localparam logic FUNC_RESTART  = 1'b1;
   localparam logic [TYPE_W-1:0] TYPE_FICTIVE = TYPE_W'(0);

   // divider: dividend is work scaled by 256, quotient has the same width
   localparam int DIV_W        = WORK_W + 8;
   localparam int DIV_BITS     = 4;
   localparam int DIV_STEPS    = DIV_W / DIV_BITS;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   dividend;
      logic [SPEED_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   // speed of one type out of a machine's row; 0 for types out of range
   function automatic logic [SPEED_W-1:0] speed_of(input logic [ROW_W-1:0] row,
                                                   input logic [TYPE_W-1:0] op);
      logic [SPEED_W-1:0] sp;
      sp = '0;
      for (int k = 0; k < TYPES; k++) begin
         if (op == TYPE_W'(k + 1)) begin
            sp = row[k*SPEED_W +: SPEED_W];
         end
      end
      return sp;
   endfunction

endpackage
`default_nettype wire

[rtl/core/efd_req_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// efd_req_if: operation channel
// Valid/ready channel carrying one dispatch or restart beat.
// ----------------------------------------------------------------------------
interface efd_req_if;
   import efd_pkg::*;

   logic              valid;
   logic              ready;
   logic              func;
   logic [TYPE_W-1:0] op_type;
   logic [TIME_W-1:0] release_time;
   logic [WORK_W-1:0] work_amount;

   modport source (output valid, func, op_type, release_time, work_amount,
                   input ready);
   modport sink   (input valid, func, op_type, release_time, work_amount,
                   output ready);
endinterface
`default_nettype wire

[rtl/core/efd_rsp_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// efd_rsp_if: dispatch result channel
// Valid/ready channel carrying one result beat per operation.
// ----------------------------------------------------------------------------
interface efd_rsp_if;
   import efd_pkg::*;

   logic                valid;
   logic                ready;
   logic [CHOSEN_W-1:0] chosen_machine;
   logic [TIME_W-1:0]   start_time;
   logic [TIME_W-1:0]   finish_time;
   logic [TIME_W-1:0]   proc_time;
   logic                skipped;
   logic                no_capable;

   modport source (output valid, chosen_machine, start_time, finish_time, proc_time,
                   skipped, no_capable, input ready);
   modport sink   (input valid, chosen_machine, start_time, finish_time, proc_time,
                   skipped, no_capable, output ready);
endinterface
`default_nettype wire

[rtl/core/efd_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// efd_div: iterative unsigned divider
// Restoring division, DIV_BITS quotient bits per cycle; done pulses for one
// cycle with the quotient valid alongside. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module efd_div (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire efd_pkg::div_req_type div_req,
   output      efd_pkg::div_rsp_type div_rsp
);
   import efd_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_W-1:0]     dvd_ff, dvd_in;
   logic [SPEED_W-1:0]   rem_ff, rem_in;
   logic [SPEED_W-1:0]   dsr_ff, dsr_in;

   logic [DIV_W-1:0]     quo_step;
   logic [SPEED_W-1:0]   rem_step;

   // DIV_BITS restoring steps per cycle
   always_comb begin
      logic [SPEED_W:0] trial;
      quo_step = dvd_ff;
      rem_step = rem_ff;
      for (int i = 0; i < DIV_BITS; i++) begin
         trial    = {rem_step, quo_step[DIV_W-1]};
         quo_step = {quo_step[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            trial       = trial - {1'b0, dsr_ff};
            quo_step[0] = 1'b1;
         end
         rem_step = trial[SPEED_W-1:0];
      end
   end

   // sequencing of the iterations
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         dvd_in = quo_step;
         rem_in = rem_step;
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule
`default_nettype wire

[rtl/core/earliest_finish_dispatch.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// earliest_finish_dispatch: earliest-finish-time list scheduler
// Walks the machines one at a time, divides work*256 by each capable
// machine's speed on a shared divider, and keeps the lowest finish.
//
//   channel   dir   handshake        payload
//   req_chan  in    valid/ready      func, op_type, release_time, work_amount
//   rsp_chan  out   valid/ready      chosen_machine, start/finish/proc_time,
//                                    skipped, no_capable
//   csr_*     in    write enable     csr_index, csr_wdata
//
// A dispatch checks each machine in a scan state; a capable one also goes
// through the divide state for the shared divider's 8 iterations and the
// compare. Restart and type 0 beats go straight to the reply state. Reset is
// synchronous and clears the control state, configuration registers and free
// times. A stalled result sits in the output register; the next beat is
// accepted meanwhile and completes once the output register frees up.
// ----------------------------------------------------------------------------
module earliest_finish_dispatch (
   input  wire logic                            clock,
   input  wire logic                            reset,
   efd_req_if.sink                              req_chan,
   efd_rsp_if.source                            rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [efd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [efd_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import efd_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_SCAN   = 5'b00010,
      ST_DIV    = 5'b00100,
      ST_COMMIT = 5'b01000,
      ST_REPLY  = 5'b10000
   } state_type;

   // configuration registers
   logic [ROW_W-1:0]  speed_row_ff [MACHINES];
   logic [TIME_W-1:0] avail_ff     [MACHINES];

   // schedule state
   logic [TIME_W-1:0] free_ff [MACHINES];

   // sequencer and working registers
   state_type         state_ff, state_in;
   logic [MACH_W-1:0] mach_ff, mach_in;
   logic              found_ff, found_in;
   logic [MACH_W-1:0] best_ff, best_in;
   logic [TIME_W-1:0] bs_ff, bs_in;
   logic [TIME_W-1:0] bf_ff, bf_in;
   logic [TIME_W-1:0] bp_ff, bp_in;
   logic [TYPE_W-1:0] type_ff, type_in;
   logic [TIME_W-1:0] rel_ff, rel_in;
   logic [WORK_W-1:0] work_ff, work_in;

   // pending result
   logic [CHOSEN_W-1:0] res_mach_ff, res_mach_in;
   logic [TIME_W-1:0]   res_start_ff, res_start_in;
   logic [TIME_W-1:0]   res_finish_ff, res_finish_in;
   logic [TIME_W-1:0]   res_proc_ff, res_proc_in;
   logic                res_skip_ff, res_skip_in;
   logic                res_nocap_ff, res_nocap_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHOSEN_W-1:0] rsp_mach_ff, rsp_mach_in;
   logic [TIME_W-1:0]   rsp_start_ff, rsp_start_in;
   logic [TIME_W-1:0]   rsp_finish_ff, rsp_finish_in;
   logic [TIME_W-1:0]   rsp_proc_ff, rsp_proc_in;
   logic                rsp_skip_ff, rsp_skip_in;
   logic                rsp_nocap_ff, rsp_nocap_in;

   logic              restart;
   logic              commit_free;
   div_req_type       div_req;
   div_rsp_type       div_rsp;

   logic              req_fire;
   logic              out_free;
   logic              last_mach;
   logic [SPEED_W-1:0] cur_speed;
   logic [TIME_W-1:0] cur_proc;
   logic [TIME_W-1:0] cur_start;
   logic [TIME_W:0]   cur_sum;
   logic [TIME_W-1:0] cur_finish;

   efd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign last_mach = (mach_ff == MACH_W'(MACHINES - 1));
   assign cur_speed = speed_of(speed_row_ff[mach_ff], type_ff);

   // candidate times for the machine under evaluation
   assign cur_proc   = div_rsp.quotient[TIME_W-1:0];
   assign cur_start  = (free_ff[mach_ff] > rel_ff) ? free_ff[mach_ff] : rel_ff;
   assign cur_sum    = {1'b0, cur_start} + {1'b0, cur_proc};
   assign cur_finish = cur_sum[TIME_W] ? {TIME_W{1'b1}} : cur_sum[TIME_W-1:0];

   assign div_req.start    = (state_ff == ST_SCAN) && (cur_speed != '0);
   assign div_req.dividend = {work_ff, 8'h00};
   assign div_req.divisor  = cur_speed;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      mach_in       = mach_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      bs_in         = bs_ff;
      bf_in         = bf_ff;
      bp_in         = bp_ff;
      type_in       = type_ff;
      rel_in        = rel_ff;
      work_in       = work_ff;
      res_mach_in   = res_mach_ff;
      res_start_in  = res_start_ff;
      res_finish_in = res_finish_ff;
      res_proc_in   = res_proc_ff;
      res_skip_in   = res_skip_ff;
      res_nocap_in  = res_nocap_ff;
      restart       = 1'b0;
      commit_free   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               type_in       = req_chan.op_type;
               rel_in        = req_chan.release_time;
               work_in       = req_chan.work_amount;
               mach_in       = '0;
               found_in      = 1'b0;
               res_mach_in   = '0;
               res_start_in  = '0;
               res_finish_in = '0;
               res_proc_in   = '0;
               res_skip_in   = 1'b0;
               res_nocap_in  = 1'b0;
               if (req_chan.func == FUNC_RESTART) begin
                  restart     = 1'b1;
                  res_skip_in = 1'b1;
                  state_in    = ST_REPLY;
               end else if (req_chan.op_type == TYPE_FICTIVE) begin
                  res_skip_in = 1'b1;
                  state_in    = ST_REPLY;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (cur_speed != '0) begin
               state_in = ST_DIV;
            end else if (last_mach) begin
               state_in = ST_COMMIT;
            end else begin
               mach_in = mach_ff + MACH_W'(1);
            end
         end
         ST_DIV: begin
            if (div_rsp.done) begin
               if (!found_ff || cur_finish < bf_ff) begin
                  found_in = 1'b1;
                  best_in  = mach_ff;
                  bs_in    = cur_start;
                  bf_in    = cur_finish;
                  bp_in    = cur_proc;
               end
               if (last_mach) begin
                  state_in = ST_COMMIT;
               end else begin
                  mach_in  = mach_ff + MACH_W'(1);
                  state_in = ST_SCAN;
               end
            end
         end
         ST_COMMIT: begin
            if (found_ff) begin
               commit_free   = 1'b1;
               res_mach_in   = CHOSEN_W'(best_ff);
               res_start_in  = bs_ff;
               res_finish_in = bf_ff;
               res_proc_in   = bp_ff;
            end else begin
               res_nocap_in = 1'b1;
            end
            state_in = ST_REPLY;
         end
         ST_REPLY: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_mach_in   = rsp_mach_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_finish_in = rsp_finish_ff;
      rsp_proc_in   = rsp_proc_ff;
      rsp_skip_in   = rsp_skip_ff;
      rsp_nocap_in  = rsp_nocap_ff;
      if ((state_ff == ST_REPLY) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_mach_in   = res_mach_ff;
         rsp_start_in  = res_start_ff;
         rsp_finish_in = res_finish_ff;
         rsp_proc_in   = res_proc_ff;
         rsp_skip_in   = res_skip_ff;
         rsp_nocap_in  = res_nocap_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mach_ff      <= '0;
         found_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         mach_ff      <= mach_in;
         found_ff     <= found_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      best_ff       <= best_in;
      bs_ff         <= bs_in;
      bf_ff         <= bf_in;
      bp_ff         <= bp_in;
      type_ff       <= type_in;
      rel_ff        <= rel_in;
      work_ff       <= work_in;
      res_mach_ff   <= res_mach_in;
      res_start_ff  <= res_start_in;
      res_finish_ff <= res_finish_in;
      res_proc_ff   <= res_proc_in;
      res_skip_ff   <= res_skip_in;
      res_nocap_ff  <= res_nocap_in;
      rsp_mach_ff   <= rsp_mach_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_finish_ff <= rsp_finish_in;
      rsp_proc_ff   <= rsp_proc_in;
      rsp_skip_ff   <= rsp_skip_in;
      rsp_nocap_ff  <= rsp_nocap_in;
   end

   // configuration registers and free times
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < MACHINES; m++) begin
            speed_row_ff[m] <= '0;
            avail_ff[m]     <= '0;
            free_ff[m]      <= '0;
         end
      end else begin
         if (csr_we) begin
            if (csr_index < CSR_AVAIL_BASE) begin
               speed_row_ff[csr_index[MACH_W-1:0]] <= csr_wdata[ROW_W-1:0];
            end else begin
               avail_ff[csr_index[MACH_W-1:0]] <= csr_wdata[TIME_W-1:0];
            end
         end
         if (restart) begin
            for (int m = 0; m < MACHINES; m++) begin
               free_ff[m] <= avail_ff[m];
            end
         end else if (commit_free) begin
            free_ff[best_ff] <= bf_ff;
         end
      end
   end

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.chosen_machine = rsp_mach_ff;
   assign rsp_chan.start_time     = rsp_start_ff;
   assign rsp_chan.finish_time    = rsp_finish_ff;
   assign rsp_chan.proc_time      = rsp_proc_ff;
   assign rsp_chan.skipped        = rsp_skip_ff;
   assign rsp_chan.no_capable     = rsp_nocap_ff;

endmodule
`default_nettype wire
